/* src/gqls_pkg.sv */
`timescale 1ns / 1ps

package gqls_pkg;

    // board and value sizes
    localparam int GRID_ROWS = 32;
    localparam int GRID_COLS = 32;
    localparam int Q_WIDTH   = 24;
    localparam int NUM_ACT   = 8;
    localparam int NUM_CELLS = GRID_ROWS * GRID_COLS;

    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int CELL_W = $clog2(NUM_CELLS);
    localparam int ACT_W  = 3;
    localparam int QROW_W = NUM_ACT * Q_WIDTH;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int RATE_W     = 17;
    localparam int MOVES_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVES = 2'd2;

    localparam logic [RATE_W-1:0]  ALPHA_RESET = 17'd52429;
    localparam logic [RATE_W-1:0]  GAMMA_RESET = 17'd64881;
    localparam logic [MOVES_W-1:0] MOVES_RESET = 8'd60;

    // update arithmetic widths
    localparam int RR_W   = 17;
    localparam int PGB_W  = Q_WIDTH + 18;
    localparam int T_W    = PGB_W + 2;
    localparam int TH_W   = T_W - 16;
    localparam int ATH_W  = TH_W + 18;
    localparam int PATL_W = 33;
    localparam int N_W    = 64;
    localparam int QT_W   = N_W - 31;

    localparam int REWARD_GOAL = 1000;
    localparam int REWARD_SAFE = 5;
    localparam int REWARD_HOLE = -1000;

    typedef logic signed [Q_WIDTH-1:0] qval_t;
    typedef logic        [QROW_W-1:0]  qrow_t;
    typedef logic signed [RR_W-1:0]    rr_t;
    typedef logic signed [PGB_W-1:0]   pgb_t;
    typedef logic signed [T_W-1:0]     tval_t;
    typedef logic signed [ATH_W-1:0]   ath_t;
    typedef logic        [PATL_W-1:0]  patl_t;
    typedef logic signed [N_W-1:0]     num_t;
    typedef logic signed [QT_W-1:0]    qt_t;
    typedef logic        [4:0]         pos_t;

    localparam qt_t QT_HI = qt_t'((64'sd1 <<< (Q_WIDTH - 1)) - 64'sd1);
    localparam qt_t QT_LO = qt_t'(-(64'sd1 <<< (Q_WIDTH - 1)));

    // directions, clockwise from up-left
    localparam logic [ACT_W-1:0] ACT_UL = 3'd0;
    localparam logic [ACT_W-1:0] ACT_U  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_UR = 3'd2;
    localparam logic [ACT_W-1:0] ACT_R  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DR = 3'd4;
    localparam logic [ACT_W-1:0] ACT_D  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DL = 3'd6;
    localparam logic [ACT_W-1:0] ACT_L  = 3'd7;
    localparam logic [ACT_W-1:0] GREEDY_DEFAULT = ACT_R;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_STEP  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_e;

    typedef enum logic [2:0] {
        ST_MOVED    = 3'd0,
        ST_ENDED    = 3'd1,
        ST_REJECTED = 3'd2,
        ST_IGNORED  = 3'd3,
        ST_ACK      = 3'd4
    } status_e;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] cell_row;
        logic [4:0] cell_col;
        logic       cell_safe;
        logic       explore;
        logic [2:0] explore_action;
    } in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [2:0]         action_taken;
        logic [4:0]         pos_row;
        logic [4:0]         pos_col;
        logic signed [23:0] new_q;
        logic               episode_over;
    } out_t;

    // controller -> datapath strobes
    typedef struct packed {
        logic capture;
        logic sweep;
        logic sweep_safe;
        logic decode;
        logic pick;
        logic rd_next;
        logic best;
        logic mul1;
        logic mul2;
        logic mul3;
        logic sum;
        logic wr;
        logic result;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last;
        logic step_go;
        logic is_clear;
        logic halt;
        logic out_free;
    } sts_t;

    function automatic logic act_illegal(input logic top_row, input logic left_col,
                                         input logic right_col, input logic [ACT_W-1:0] act);
        return (top_row   && (act == ACT_UL || act == ACT_U  || act == ACT_UR)) ||
               (left_col  && (act == ACT_UL || act == ACT_DL || act == ACT_L))  ||
               (right_col && (act == ACT_UR || act == ACT_R  || act == ACT_DR));
    endfunction

    function automatic logic signed [1:0] act_drow(input logic [ACT_W-1:0] act);
        logic signed [1:0] d;
        unique case (act)
            ACT_UL, ACT_U, ACT_UR: d = -2'sd1;
            ACT_DR, ACT_D, ACT_DL: d = 2'sd1;
            default:               d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] act_dcol(input logic [ACT_W-1:0] act);
        logic signed [1:0] d;
        unique case (act)
            ACT_UL, ACT_DL, ACT_L: d = -2'sd1;
            ACT_UR, ACT_R, ACT_DR: d = 2'sd1;
            default:               d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic [CELL_W-1:0] cell_of(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        return CELL_W'(int'(row) * GRID_COLS + int'(col));
    endfunction

endpackage

/* src/gqls_ram.sv */
`timescale 1ns / 1ps

module gqls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/gqls_ctrl.sv */
`timescale 1ns / 1ps

module gqls_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output gqls_pkg::cmd_t  cmd,
    input  gqls_pkg::sts_t  sts
);

    typedef enum logic [12:0] {
        S_INIT   = 13'h0001,
        S_IDLE   = 13'h0002,
        S_DECODE = 13'h0004,
        S_CLEAR  = 13'h0008,
        S_PICK   = 13'h0010,
        S_RDNEXT = 13'h0020,
        S_BEST   = 13'h0040,
        S_MUL1   = 13'h0080,
        S_MUL2   = 13'h0100,
        S_MUL3   = 13'h0200,
        S_SUM    = 13'h0400,
        S_WRITE  = 13'h0800,
        S_DONE   = 13'h1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep      = 1'b1;
                cmd.sweep_safe = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.is_clear)
                begin
                    state_next = S_CLEAR;
                end
                else if (sts.step_go)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_RDNEXT;
            end
            S_RDNEXT:
            begin
                cmd.rd_next = 1'b1;
                state_next  = sts.halt ? S_DONE : S_BEST;
            end
            S_BEST:
            begin
                cmd.best   = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.result = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

/* src/gqls_dp.sv */
`timescale 1ns / 1ps

module gqls_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gqls_pkg::in_t                       in_data,
    input  logic                                cfg_we,
    input  logic [gqls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gqls_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output gqls_pkg::out_t                      out_data,
    input  gqls_pkg::cmd_t                      cmd,
    output gqls_pkg::sts_t                      sts
);

    // control state
    logic [gqls_pkg::RATE_W-1:0]  alpha_reg, alpha_next;
    logic [gqls_pkg::RATE_W-1:0]  gamma_reg, gamma_next;
    logic [gqls_pkg::MOVES_W-1:0] maxm_reg, maxm_next;
    logic [gqls_pkg::ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [gqls_pkg::COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [gqls_pkg::MOVES_W-1:0] moves_reg, moves_next;
    logic                         ended_reg, ended_next;
    logic [gqls_pkg::CELL_W-1:0]  sweep_reg, sweep_next;
    logic                         out_valid_reg, out_valid_next;

    // payload
    gqls_pkg::in_t                in_reg;
    logic [2:0]                   res_status_reg, res_status_next;
    logic [gqls_pkg::ACT_W-1:0]   act_reg, act_next;
    gqls_pkg::qval_t              nq_reg, nq_next;
    logic                         halt_reg, halt_next;
    logic [gqls_pkg::ROW_W-1:0]   nrow_reg, nrow_next;
    logic [gqls_pkg::COL_W-1:0]   ncol_reg, ncol_next;
    gqls_pkg::qrow_t              prow_reg, prow_next;
    gqls_pkg::qval_t              qold_reg, qold_next;
    gqls_pkg::qval_t              best_reg, best_next;
    gqls_pkg::rr_t                rr_reg, rr_next;
    logic                         safe_n_reg, safe_n_next;
    gqls_pkg::pgb_t               p_gb_reg, p_gb_next;
    gqls_pkg::pgb_t               p_qa_reg, p_qa_next;
    gqls_pkg::tval_t              t_reg, t_next;
    gqls_pkg::ath_t               p_ath_reg, p_ath_next;
    gqls_pkg::patl_t              p_atl_reg, p_atl_next;
    gqls_pkg::num_t               n_reg, n_next;
    gqls_pkg::out_t               out_reg, out_next;

    // memories
    logic                         q_we;
    logic [gqls_pkg::CELL_W-1:0]  q_waddr;
    gqls_pkg::qrow_t              q_wdata;
    logic [gqls_pkg::CELL_W-1:0]  rd_addr;
    gqls_pkg::qrow_t              q_rdata;
    logic                         s_we;
    logic [gqls_pkg::CELL_W-1:0]  s_waddr;
    logic                         s_wdata;
    logic                         s_rdata;

    // helpers
    gqls_pkg::qval_t              qv [gqls_pkg::NUM_ACT];
    logic [gqls_pkg::NUM_ACT-1:0] illegal_v;
    logic [gqls_pkg::ACT_W-1:0]   greedy_act;
    logic [gqls_pkg::ACT_W-1:0]   pick_act;
    gqls_pkg::qval_t              best_v;
    int                           nr_i, nc_i;
    logic                         load_ok;
    logic                         last_row;
    logic                         top_row, left_col, right_col;
    logic [gqls_pkg::CELL_W-1:0]  pcell, ncell;
    logic signed [17:0]           one_minus_a;
    logic                         round_up;
    gqls_pkg::qt_t                qt;
    gqls_pkg::qval_t              qsat;
    gqls_pkg::qrow_t              wrow;

    assign pcell   = gqls_pkg::cell_of(cur_row_reg, cur_col_reg);
    assign ncell   = gqls_pkg::cell_of(nrow_reg, ncol_reg);
    assign rd_addr = cmd.rd_next ? ncell : pcell;

    assign load_ok  = (int'(in_reg.cell_row) < gqls_pkg::GRID_ROWS) &&
                      (int'(in_reg.cell_col) < gqls_pkg::GRID_COLS);
    assign last_row = (nrow_reg == gqls_pkg::ROW_W'(gqls_pkg::GRID_ROWS - 1));
    assign top_row   = (cur_row_reg == '0);
    assign left_col  = (cur_col_reg == '0);
    assign right_col = (cur_col_reg == gqls_pkg::COL_W'(gqls_pkg::GRID_COLS - 1));

    gqls_ram #(
        .WIDTH (gqls_pkg::QROW_W),
        .DEPTH (gqls_pkg::NUM_CELLS)
    ) u_q_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (rd_addr),
        .rdata (q_rdata)
    );

    gqls_ram #(
        .WIDTH (1),
        .DEPTH (gqls_pkg::NUM_CELLS)
    ) u_safe_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (rd_addr),
        .rdata (s_rdata)
    );

    // row unpack, legality, greedy pick, row max
    always_comb
    begin
        for (int x = 0; x < gqls_pkg::NUM_ACT; x++)
        begin
            qv[x]        = q_rdata[x*gqls_pkg::Q_WIDTH +: gqls_pkg::Q_WIDTH];
            illegal_v[x] = gqls_pkg::act_illegal(top_row, left_col, right_col,
                                                 gqls_pkg::ACT_W'(x));
        end
    end

    always_comb
    begin
        greedy_act = gqls_pkg::GREEDY_DEFAULT;
        for (int x = 0; x < gqls_pkg::NUM_ACT; x++)
        begin
            if (!illegal_v[x] && (qv[x] > qv[greedy_act]))
            begin
                greedy_act = gqls_pkg::ACT_W'(x);
            end
        end
    end

    always_comb
    begin
        best_v = qv[0];
        for (int x = 1; x < gqls_pkg::NUM_ACT; x++)
        begin
            if (qv[x] > best_v)
            begin
                best_v = qv[x];
            end
        end
    end

    assign pick_act = in_reg.explore ? in_reg.explore_action : greedy_act;
    assign nr_i = int'(cur_row_reg) + int'(gqls_pkg::act_drow(pick_act));
    assign nc_i = int'(cur_col_reg) + int'(gqls_pkg::act_dcol(pick_act));

    // final rounding toward zero and saturation
    assign round_up = n_reg[gqls_pkg::N_W-1] && (n_reg[31:0] != '0);
    assign qt = $signed({n_reg[gqls_pkg::N_W-1], n_reg[gqls_pkg::N_W-1:32]})
                + gqls_pkg::qt_t'(round_up);
    always_comb
    begin
        priority if (qt > gqls_pkg::QT_HI)
        begin
            qsat = gqls_pkg::qval_t'(gqls_pkg::QT_HI);
        end
        else if (qt < gqls_pkg::QT_LO)
        begin
            qsat = gqls_pkg::qval_t'(gqls_pkg::QT_LO);
        end
        else
        begin
            qsat = gqls_pkg::qval_t'(qt);
        end
    end

    always_comb
    begin
        wrow = prow_reg;
        wrow[act_reg*gqls_pkg::Q_WIDTH +: gqls_pkg::Q_WIDTH] = qsat;
    end

    assign one_minus_a = 18'sh10000 - $signed({1'b0, alpha_reg});

    // memory ports
    assign q_we    = cmd.sweep || cmd.wr;
    assign q_waddr = cmd.sweep ? sweep_reg : pcell;
    assign q_wdata = cmd.sweep ? '0 : wrow;
    assign s_we    = (cmd.sweep && cmd.sweep_safe) ||
                     (cmd.decode && (gqls_pkg::mode_e'(in_reg.mode) == gqls_pkg::MODE_LOAD)
                      && load_ok);
    assign s_waddr = cmd.sweep ? sweep_reg
                               : gqls_pkg::cell_of(gqls_pkg::ROW_W'(in_reg.cell_row),
                                                   gqls_pkg::COL_W'(in_reg.cell_col));
    assign s_wdata = cmd.sweep ? 1'b1 : in_reg.cell_safe;

    // status to controller
    assign sts.sweep_last = (sweep_reg == gqls_pkg::CELL_W'(gqls_pkg::NUM_CELLS - 1));
    assign sts.step_go    = (gqls_pkg::mode_e'(in_reg.mode) == gqls_pkg::MODE_STEP) && !ended_reg;
    assign sts.is_clear   = (gqls_pkg::mode_e'(in_reg.mode) == gqls_pkg::MODE_CLEAR);
    assign sts.halt       = halt_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        alpha_next      = alpha_reg;
        gamma_next      = gamma_reg;
        maxm_next       = maxm_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        moves_next      = moves_reg;
        ended_next      = ended_reg;
        sweep_next      = sweep_reg;
        out_valid_next  = out_valid_reg;
        res_status_next = res_status_reg;
        act_next        = act_reg;
        nq_next         = nq_reg;
        halt_next       = halt_reg;
        nrow_next       = nrow_reg;
        ncol_next       = ncol_reg;
        prow_next       = prow_reg;
        qold_next       = qold_reg;
        best_next       = best_reg;
        rr_next         = rr_reg;
        safe_n_next     = safe_n_reg;
        p_gb_next       = p_gb_reg;
        p_qa_next       = p_qa_reg;
        t_next          = t_reg;
        p_ath_next      = p_ath_reg;
        p_atl_next      = p_atl_reg;
        n_next          = n_reg;
        out_next        = out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                gqls_pkg::CFG_ALPHA: alpha_next = gqls_pkg::RATE_W'(cfg_data);
                gqls_pkg::CFG_GAMMA: gamma_next = gqls_pkg::RATE_W'(cfg_data);
                gqls_pkg::CFG_MOVES: maxm_next  = gqls_pkg::MOVES_W'(cfg_data);
                default: ;
            endcase
        end

        if (cmd.sweep)
        begin
            sweep_next = sts.sweep_last ? '0 : sweep_reg + 1'b1;
        end

        if (cmd.decode)
        begin
            act_next        = '0;
            nq_next         = '0;
            res_status_next = gqls_pkg::ST_ACK;
            unique case (gqls_pkg::mode_e'(in_reg.mode))
                gqls_pkg::MODE_LOAD:
                begin
                    if (!load_ok)
                    begin
                        res_status_next = gqls_pkg::ST_IGNORED;
                    end
                end
                gqls_pkg::MODE_START:
                begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                    moves_next   = '0;
                    ended_next   = 1'b0;
                end
                gqls_pkg::MODE_STEP:
                begin
                    if (ended_reg)
                    begin
                        res_status_next = gqls_pkg::ST_IGNORED;
                    end
                end
                gqls_pkg::MODE_CLEAR: ;
            endcase
        end

        if (cmd.pick)
        begin
            act_next  = pick_act;
            prow_next = q_rdata;
            qold_next = qv[pick_act];
            nrow_next = gqls_pkg::ROW_W'(nr_i);
            ncol_next = gqls_pkg::COL_W'(nc_i);
            halt_next = 1'b0;
            if (in_reg.explore && illegal_v[pick_act])
            begin
                res_status_next = gqls_pkg::ST_REJECTED;
                halt_next       = 1'b1;
            end
            else
            begin
                moves_next = moves_reg + 1'b1;
                if (nr_i < 0 || nc_i < 0 || nr_i >= gqls_pkg::GRID_ROWS ||
                    nc_i >= gqls_pkg::GRID_COLS)
                begin
                    ended_next      = 1'b1;
                    res_status_next = gqls_pkg::ST_ENDED;
                    halt_next       = 1'b1;
                end
            end
        end

        if (cmd.best)
        begin
            best_next   = best_v;
            safe_n_next = s_rdata;
            priority if (last_row)
            begin
                rr_next = gqls_pkg::RR_W'(gqls_pkg::REWARD_GOAL * (gqls_pkg::GRID_ROWS - 1));
            end
            else if (s_rdata)
            begin
                rr_next = gqls_pkg::RR_W'(int'(nrow_reg) * gqls_pkg::REWARD_SAFE);
            end
            else
            begin
                rr_next = gqls_pkg::RR_W'(int'(nrow_reg) * gqls_pkg::REWARD_HOLE);
            end
        end

        if (cmd.mul1)
        begin
            p_gb_next = $signed({1'b0, gamma_reg}) * best_reg;
            p_qa_next = one_minus_a * qold_reg;
        end

        if (cmd.mul2)
        begin
            t_next = (gqls_pkg::tval_t'(rr_reg) <<< 16) + gqls_pkg::tval_t'(p_gb_reg);
        end

        if (cmd.mul3)
        begin
            p_ath_next = $signed({1'b0, alpha_reg}) * $signed(t_reg[gqls_pkg::T_W-1:16]);
            p_atl_next = alpha_reg * t_reg[15:0];
        end

        if (cmd.sum)
        begin
            n_next = ((gqls_pkg::num_t'(p_qa_reg) + gqls_pkg::num_t'(p_ath_reg)) <<< 16)
                     + $signed({{(gqls_pkg::N_W - gqls_pkg::PATL_W){1'b0}}, p_atl_reg});
        end

        if (cmd.wr)
        begin
            nq_next         = qsat;
            cur_row_next    = nrow_reg;
            cur_col_next    = ncol_reg;
            res_status_next = gqls_pkg::ST_MOVED;
            if (!safe_n_reg || last_row || (moves_reg >= maxm_reg))
            begin
                ended_next      = 1'b1;
                res_status_next = gqls_pkg::ST_ENDED;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.result)
        begin
            out_valid_next        = 1'b1;
            out_next.status       = res_status_reg;
            out_next.action_taken = act_reg;
            out_next.pos_row      = gqls_pkg::pos_t'(cur_row_reg);
            out_next.pos_col      = gqls_pkg::pos_t'(cur_col_reg);
            out_next.new_q        = nq_reg;
            out_next.episode_over = ended_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= gqls_pkg::ALPHA_RESET;
            gamma_reg     <= gqls_pkg::GAMMA_RESET;
            maxm_reg      <= gqls_pkg::MOVES_RESET;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            moves_reg     <= '0;
            ended_reg     <= 1'b1;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            halt_reg      <= 1'b0;
        end
        else
        begin
            alpha_reg     <= alpha_next;
            gamma_reg     <= gamma_next;
            maxm_reg      <= maxm_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            moves_reg     <= moves_next;
            ended_reg     <= ended_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
            halt_reg      <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_data;
        end
        res_status_reg <= res_status_next;
        act_reg        <= act_next;
        nq_reg         <= nq_next;
        nrow_reg       <= nrow_next;
        ncol_reg       <= ncol_next;
        prow_reg       <= prow_next;
        qold_reg       <= qold_next;
        best_reg       <= best_next;
        rr_reg         <= rr_next;
        safe_n_reg     <= safe_n_next;
        p_gb_reg       <= p_gb_next;
        p_qa_reg       <= p_qa_next;
        t_reg          <= t_next;
        p_ath_reg      <= p_ath_next;
        p_atl_reg      <= p_atl_next;
        n_reg          <= n_next;
        out_reg        <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* src/grid_q_learning_step_top.sv */
`timescale 1ns / 1ps

// Channel   Handshake               Payload                       Notes
// in        in_valid / in_ready     in_data   (gqls_pkg::in_t)    one command per request
// out       out_valid / out_ready   out_data  (gqls_pkg::out_t)   one result per request
// cfg       cfg_we                  cfg_index, cfg_data           write only, no stall
//
// Steps: a load, start or ignored step goes from accept through decode to result;
//   a rejected or off-board step adds pick and next-row read; a full step runs row
//   read, greedy pick, next-row read, max, three multiply stages, sum, write-back; a clear
//   sweeps every cell. The Q row memory read and multiply chain set the step length.
// Reset: a sweep of every cell zeroes the Q memory and marks every cell safe;
//   in_ready stays low until it completes. Config writes are taken throughout.
// Stalls: the result sits in an output register; the controller waits only if
//   a new result is ready while the previous one has not been taken.

module grid_q_learning_step_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  gqls_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output gqls_pkg::out_t                     out_data,
    input  logic                               cfg_we,
    input  logic [gqls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gqls_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // strobes from the sequencer and status flags back
    gqls_pkg::cmd_t cmd;
    gqls_pkg::sts_t sts;

    // sequencer: reset sweep, decode, clear sweep, step phases, result hand-off
    gqls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath: Q row memory (one row = all eight actions), cell map,
    // episode state, config registers, fixed-point update, output register
    gqls_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* src/gqls_checker.sv */
`timescale 1ns / 1ps

module gqls_sva (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input gqls_pkg::out_t                     out_data
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == gqls_pkg::ST_ACK |->
            out_data.action_taken == '0 && out_data.new_q == '0)
        else $error("acknowledge carries action or value");

    a_noupd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == gqls_pkg::ST_REJECTED ||
                      out_data.status == gqls_pkg::ST_IGNORED) |-> out_data.new_q == '0)
        else $error("no-update result carries a value");

    a_moved_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == gqls_pkg::ST_MOVED |-> !out_data.episode_over)
        else $error("moved but episode over");

    a_ended_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == gqls_pkg::ST_ENDED |-> out_data.episode_over)
        else $error("ended without episode flag");

endmodule

bind grid_q_learning_step_top gqls_sva u_checker (.*);
